// ===== src/task_id_next_fit_allocator_macros.svh =====
// Assertion shorthands shared by the allocator RTL.
// Both expect clk_i and rst_ni in scope.
`ifndef TASK_ID_NEXT_FIT_ALLOCATOR_MACROS_SVH
`define TASK_ID_NEXT_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication
`define TIDNF_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tidnf: same-cycle check failed");

// Next-cycle implication
`define TIDNF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tidnf: next-cycle check failed");

`endif

// ===== src/tidnf_pkg.sv =====
package tidnf_pkg;

  // Table geometry
  localparam int ID_DEPTH = 1024;
  localparam int ID_W     = $clog2(ID_DEPTH);
  localparam int LIM_W    = ID_W + 1;
  localparam int QUEUE_W  = 6;
  localparam int HANDLE_W = 16;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_PLACE  = 2'd1,
    OP_TERM   = 2'd2,
    OP_LOOKUP = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LOOK,
    S_WRAP,
    S_SCAN,
    S_FINISH
  } state_e;

  // One slot of the ID table
  typedef struct packed {
    logic                vld;
    logic [QUEUE_W-1:0]  queue;
    logic [HANDLE_W-1:0] task_h;
    logic [HANDLE_W-1:0] flow_h;
  } entry_t;

  typedef struct packed {
    op_e                 op;
    logic [ID_W-1:0]     gid;
    logic [QUEUE_W-1:0]  queue;
    logic [HANDLE_W-1:0] task_h;
    logic [HANDLE_W-1:0] flow_h;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     id;
    logic [QUEUE_W-1:0]  queue;
    logic [HANDLE_W-1:0] task_h;
    logic [HANDLE_W-1:0] flow_h;
  } rsp_t;

  // Controller to slot memory
  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] waddr;
    entry_t          wdata;
    logic [ID_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== src/tidnf_ifs.sv =====
// Request channel
interface tidnf_req_if import tidnf_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [ID_W-1:0]     given_id;
  logic [QUEUE_W-1:0]  queue_index;
  logic [HANDLE_W-1:0] task_handle;
  logic [HANDLE_W-1:0] workflow_handle;

  modport source (output valid, opcode, given_id, queue_index, task_handle,
                  workflow_handle, input ready);
  modport sink (input valid, opcode, given_id, queue_index, task_handle,
                workflow_handle, output ready);
endinterface

// Result channel
interface tidnf_rsp_if import tidnf_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [ID_W-1:0]     result_id;
  logic [QUEUE_W-1:0]  held_queue;
  logic [HANDLE_W-1:0] held_task;
  logic [HANDLE_W-1:0] held_workflow;

  modport source (output valid, status, result_id, held_queue, held_task,
                  held_workflow, input ready);
  modport sink (input valid, status, result_id, held_queue, held_task,
                held_workflow, output ready);
endinterface

// ===== src/tidnf_ram.sv =====
// Slot table: one write port, one read port, registered read data.
module tidnf_ram import tidnf_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t mem_i,
  output entry_t   rdata_o
);

  entry_t slot_mem [ID_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      slot_mem[mem_i.waddr] <= mem_i.wdata;
    end
    rdata_q <= slot_mem[mem_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tidnf_ctrl.sv =====
`include "task_id_next_fit_allocator_macros.svh"

// Command sequencer: clearing pass, read-modify-write of slots and the
// next-fit scan. One command is in flight at a time, so a slot write always
// lands before the next command reads the table.
module tidnf_ctrl import tidnf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LIM_W-1:0] limit_i,
  input  logic             req_valid_i,
  input  req_t             req_i,
  output logic             idle_o,
  input  logic             res_free_i,
  output logic             res_load_o,
  output rsp_t             res_o,
  output mem_req_t         mem_o,
  input  entry_t           mem_rdata_i
);

  state_e           state_q, state_d;
  logic [ID_W-1:0]  last_q, last_d;
  logic [ID_W-1:0]  clr_q, clr_d;
  logic             chk_v_q, chk_v_d;
  logic [ID_W-1:0]  chk_id_q, chk_id_d;
  logic [LIM_W-1:0] cand_q, cand_d;
  logic [LIM_W-1:0] issued_q, issued_d;
  logic [LIM_W-1:0] cand_inc;
  req_t             req_q, req_d;
  rsp_t             res_q, res_d;
  logic             gid_bad;
  logic             found;
  entry_t           new_entry;

  assign gid_bad   = (req_q.gid == '0) || ({1'b0, req_q.gid} >= limit_i);
  assign found     = chk_v_q && (chk_id_q != '0) && !mem_rdata_i.vld;
  assign cand_inc  = cand_q + LIM_W'(1);
  assign new_entry = '{vld: 1'b1, queue: req_q.queue, task_h: req_q.task_h,
                       flow_h: req_q.flow_h};

  // Next state, memory access and result
  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    clr_d      = clr_q;
    chk_v_d    = chk_v_q;
    chk_id_d   = chk_id_q;
    cand_d     = cand_q;
    issued_d   = issued_q;
    req_d      = req_q;
    res_d      = res_q;
    res_load_o = 1'b0;
    mem_o      = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = clr_q;
        clr_d       = clr_q + ID_W'(1);
        if (clr_q == ID_W'(ID_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_d = '0;
        priority if (req_q.op == OP_ALLOC) begin
          cand_d  = {1'b0, last_q} + LIM_W'(1);
          state_d = S_WRAP;
        end else if (gid_bad) begin
          res_d.status = ST_NOT_FOUND;
          state_d      = S_FINISH;
        end else if (req_q.op == OP_PLACE) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = req_q.gid;
          mem_o.wdata = new_entry;
          res_d.id    = req_q.gid;
          state_d     = S_FINISH;
        end else begin
          mem_o.raddr = req_q.gid;
          state_d     = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!mem_rdata_i.vld) begin
          res_d.status = ST_NOT_FOUND;
        end else begin
          res_d.id     = req_q.gid;
          res_d.queue  = mem_rdata_i.queue;
          res_d.task_h = mem_rdata_i.task_h;
          res_d.flow_h = mem_rdata_i.flow_h;
          // terminate frees the slot
          if (req_q.op == OP_TERM) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = req_q.gid;
          end
        end
        state_d = S_FINISH;
      end
      S_WRAP: begin
        // bring the start point below the limit
        if (cand_q >= limit_i) begin
          cand_d = cand_q - limit_i;
        end else begin
          issued_d = '0;
          chk_v_d  = 1'b0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one read per cycle, check the one issued last cycle
        priority if (found) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = chk_id_q;
          mem_o.wdata = new_entry;
          last_d      = chk_id_q;
          res_d.id    = chk_id_q;
          state_d     = S_FINISH;
        end else if (issued_q == limit_i) begin
          res_d.status = ST_NO_FREE;
          state_d      = S_FINISH;
        end else begin
          mem_o.raddr = cand_q[ID_W-1:0];
          chk_v_d     = 1'b1;
          chk_id_d    = cand_q[ID_W-1:0];
          cand_d      = (cand_inc == limit_i) ? '0 : cand_inc;
          issued_d    = issued_q + LIM_W'(1);
        end
      end
      S_FINISH: begin
        if (res_free_i) begin
          res_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      last_q  <= '0;
      clr_q   <= '0;
      chk_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      clr_q   <= clr_d;
      chk_v_q <= chk_v_d;
    end
  end

  // Payload and scan working registers
  always_ff @(posedge clk_i) begin
    chk_id_q <= chk_id_d;
    cand_q   <= cand_d;
    issued_q <= issued_d;
    req_q    <= req_d;
    res_q    <= res_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign res_o  = res_q;

  `TIDNF_ASSERT_IMPL(a_load_free, res_load_o, res_free_i)
  `TIDNF_ASSERT_IMPL(a_no_id0, (state_q == S_SCAN) && mem_o.we, mem_o.waddr != '0)
  `TIDNF_ASSERT_IMPL(a_scan_bound, state_q == S_SCAN, issued_q <= limit_i)
  `TIDNF_ASSERT_NEXT(a_accept_dec, idle_o && req_valid_i, state_q == S_DECODE)

endmodule

// ===== src/task_id_next_fit_allocator.sv =====
// Next-fit task ID allocator. After reset the block sweeps its 1024-entry
// slot table once to clear the occupancy bits, with ready low; id_limit
// writes are taken during that time. Each command then runs alone through
// the slot memory (one read and one write port, registered read data):
// place or a rejected ID goes from decode straight to the result, while
// lookup and terminate read the slot first. Allocate subtracts the limit as
// often as needed to bring the ID after the last one given below the limit,
// then scans occupancy one slot per cycle from there, probing at most the
// effective limit of slots. A new request is taken while a finished result
// still waits in the output register.
module task_id_next_fit_allocator import tidnf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LIM_W-1:0] cfg_wdata_i,
  tidnf_req_if.sink        req_i,
  tidnf_rsp_if.source      rsp_o
);

  logic [LIM_W-1:0] limit_q;
  logic [LIM_W-1:0] eff_limit;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q;
  req_t             req;
  rsp_t             res;
  logic             res_free;
  logic             res_load;
  logic             idle;
  mem_req_t         mem_req;
  entry_t           mem_rdata;

  // Limit register and clamp to [2, ID_DEPTH]
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIM_W'(ID_DEPTH);
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    priority if (limit_q < LIM_W'(2)) begin
      eff_limit = LIM_W'(2);
    end else if (limit_q > LIM_W'(ID_DEPTH)) begin
      eff_limit = LIM_W'(ID_DEPTH);
    end else begin
      eff_limit = limit_q;
    end
  end

  assign req = '{op: op_e'(req_i.opcode), gid: req_i.given_id,
                 queue: req_i.queue_index, task_h: req_i.task_handle,
                 flow_h: req_i.workflow_handle};
  assign req_i.ready = idle;

  tidnf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (eff_limit),
    .req_valid_i (req_i.valid),
    .req_i       (req),
    .idle_o      (idle),
    .res_free_i  (res_free),
    .res_load_o  (res_load),
    .res_o       (res),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  tidnf_ram u_ram (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register
  assign res_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.result_id     = out_q.id;
  assign rsp_o.held_queue    = out_q.queue;
  assign rsp_o.held_task     = out_q.task_h;
  assign rsp_o.held_workflow = out_q.flow_h;

endmodule
